/* sv/assert_macros.svh */
// Assertion macros shared by the search block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KNN_ASSERT(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("knn assertion failed");
`define KNN_ASSERT_NEVER(name, clk, rstn, cond) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
	else $error("knn forbidden condition seen");
`else
`define KNN_ASSERT(name, clk, rstn, prop)
`define KNN_ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

/* sv/knn_pkg.sv */
// Shared constants and types of the nearest-neighbour search block.
package knn_pkg;
	localparam int MAX_DATA  = 1024;
	localparam int MAX_DIM   = 128;
	localparam int MAX_K     = 64;
	localparam int ELEM_BITS = 16;

	localparam int VEC_W   = 10;
	localparam int ELEM_W  = 7;
	localparam int DB_AW   = VEC_W + ELEM_W;
	localparam int SCORE_W = 44;
	localparam int RANK_W  = 6;
	localparam int CNT_W   = 7;
	localparam int CFG_W   = 11;
	localparam int CFGI_W  = 2;

	localparam logic [CFGI_W-1:0] CFG_METRIC = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_DIM    = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_NDATA  = 2'd2;
	localparam logic [CFGI_W-1:0] CFG_K      = 2'd3;

	typedef logic signed [SCORE_W-1:0] score_t;

	// Tag that travels with one element read through the score pipeline.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [VEC_W-1:0] idx;
	} issue_t;

	// Finished score of one stored vector.
	typedef struct packed {
		logic             valid;
		score_t           score;
		logic [VEC_W-1:0] idx;
	} score_res_t;

	// Commands from the sequencer to the ranked list.
	typedef struct packed {
		logic             clear;
		logic             pop;
		logic             metric;
		logic [CNT_W-1:0] k;
	} list_ctl_t;
endpackage

/* sv/knn_if.sv */
// Valid/ready channels for input items and results.
interface knn_item_if;
	import knn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    op;
	logic [VEC_W-1:0]        vec_index;
	logic [ELEM_W-1:0]       elem_index;
	logic signed [ELEM_BITS-1:0] value;
	modport source (output valid, op, vec_index, elem_index, value, input ready);
	modport sink (input valid, op, vec_index, elem_index, value, output ready);
endinterface

interface knn_result_if;
	import knn_pkg::*;
	logic               valid;
	logic               ready;
	logic [RANK_W-1:0]  rank;
	logic signed [SCORE_W-1:0] score;
	logic [VEC_W-1:0]   data_index;
	logic               last;
	modport source (output valid, rank, score, data_index, last, input ready);
	modport sink (input valid, rank, score, data_index, last, output ready);
endinterface

/* sv/knn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module knn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/knn_score.sv */
// Shared multiply-accumulate pipeline scoring one element per cycle.
module knn_score (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        metric,
	input  knn_pkg::issue_t             tag_s0,
	input  logic signed [knn_pkg::ELEM_BITS-1:0] q_data,
	input  logic signed [knn_pkg::ELEM_BITS-1:0] d_data,
	output knn_pkg::score_res_t         res,
	output logic                        busy
);
	import knn_pkg::*;

	localparam int OP_W   = ELEM_BITS + 1;
	localparam int PROD_W = 2 * OP_W;

	issue_t                   tag_s1, tag_s2, tag_s3;
	logic signed [OP_W-1:0]   a_s2, b_s2;
	logic signed [PROD_W-1:0] prod_s3;
	score_t                   acc_q;
	logic                     done_s4;
	logic [VEC_W-1:0]         idx_s4;
	logic signed [OP_W-1:0]   q_ext, d_ext, diff;

	assign q_ext = OP_W'(q_data);
	assign d_ext = OP_W'(d_data);
	assign diff  = q_ext - d_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_s3  <= '0;
			done_s4 <= 1'b0;
		end else begin
			tag_s1  <= tag_s0;
			tag_s2  <= tag_s1;
			tag_s3  <= tag_s2;
			done_s4 <= tag_s3.valid && tag_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		a_s2 <= metric ? q_ext : diff;
		b_s2 <= metric ? d_ext : diff;
		prod_s3 <= a_s2 * b_s2;
		if (tag_s3.valid) begin
			acc_q <= (tag_s3.first ? score_t'(0) : acc_q) + SCORE_W'(prod_s3);
		end
		idx_s4 <= tag_s3.idx;
	end

	assign res.valid = done_s4;
	assign res.score = acc_q;
	assign res.idx   = idx_s4;
	assign busy = tag_s1.valid || tag_s2.valid || tag_s3.valid || done_s4;
endmodule

/* sv/knn_topk.sv */
// Row of ranked cells holding the best scores; drains from the head.
`include "assert_macros.svh"
module knn_topk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  knn_pkg::list_ctl_t         ctl,
	input  knn_pkg::score_res_t        ins,
	output knn_pkg::score_t            head_score,
	output logic [knn_pkg::VEC_W-1:0]  head_idx,
	output logic [knn_pkg::CNT_W-1:0]  count
);
	import knn_pkg::*;

	score_t           score_q [MAX_K];
	logic [VEC_W-1:0] idx_q   [MAX_K];
	logic [MAX_K-1:0] vld_q;
	logic [CNT_W-1:0] count_q;
	logic [MAX_K-1:0] gt;
	logic [MAX_K-1:0] take;

	// A cell is beaten when empty or when the new score ranks strictly ahead.
	// Only the first empty cell may take the item, so the row stays a prefix.
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			gt[i] = !vld_q[i] ||
				(ctl.metric ? (ins.score > score_q[i]) : (ins.score < score_q[i]));
			take[i] = (CNT_W'(i) < ctl.k) && gt[i] &&
				((i == 0) || vld_q[(i == 0) ? 0 : i-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			count_q <= '0;
		end else if (ctl.clear) begin
			vld_q   <= '0;
			count_q <= '0;
		end else if (ins.valid) begin
			for (int i = 0; i < MAX_K; i++) begin
				if (take[i]) begin
					vld_q[i] <= 1'b1;
				end
			end
			if (count_q < ctl.k) begin
				count_q <= count_q + 1'b1;
			end
		end else if (ctl.pop) begin
			vld_q   <= {1'b0, vld_q[MAX_K-1:1]};
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ins.valid && !ctl.clear) begin
			for (int i = 0; i < MAX_K; i++) begin
				if (take[i]) begin
					if (i == 0) begin
						score_q[i] <= ins.score;
						idx_q[i]   <= ins.idx;
					end else if (!gt[(i == 0) ? 0 : i-1]) begin
						score_q[i] <= ins.score;
						idx_q[i]   <= ins.idx;
					end else begin
						score_q[i] <= score_q[(i == 0) ? 0 : i-1];
						idx_q[i]   <= idx_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end else if (ctl.pop && !ctl.clear) begin
			for (int i = 0; i < MAX_K - 1; i++) begin
				score_q[i] <= score_q[i+1];
				idx_q[i]   <= idx_q[i+1];
			end
		end
	end

	assign head_score = score_q[0];
	assign head_idx   = idx_q[0];
	assign count      = count_q;

	`KNN_ASSERT(a_count_le_k, clk, arst_n, ins.valid |=> count_q <= ctl.k)
	`KNN_ASSERT_NEVER(a_pop_empty, clk, arst_n, ctl.pop && count_q == '0)
	`KNN_ASSERT_NEVER(a_pop_during_insert, clk, arst_n, ctl.pop && ins.valid)
	`KNN_ASSERT(a_count_matches_valid, clk, arst_n,
		$countones(vld_q) == int'(count_q))
endmodule

/* sv/brute_force_knn_topk.sv */
// Exact k-nearest-neighbour search: database and query loading, scan sequencer, result drain.
// Items with op 0 write one database element; op 1 items store a query element, and the one at
// position dim_in_use-1 starts a search. The search reads one element pair per cycle through a
// single multiply-accumulate pipeline, covering n_data_in_use * dim_in_use pairs and then waiting
// for the pipeline to drain, with the item port not ready meanwhile; each finished vector score
// is ranked into the top-k row alongside the scan. The best k results then leave one per cycle
// while the result receiver is ready, from the head of the row, lowest rank first, and the port
// takes items again after the result marked last.
`include "assert_macros.svh"
module brute_force_knn_topk (
	input  logic                          clk,
	input  logic                          arst_n,
	knn_item_if.sink                      item_ch,
	knn_result_if.source                  result_ch,
	input  logic                          cfg_we,
	input  logic [knn_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [knn_pkg::CFG_W-1:0]     cfg_data
);
	import knn_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q;
	logic             metric_q;
	logic [7:0]       dim_q;
	logic [10:0]      ndata_q;
	logic [CNT_W-1:0] k_q;
	logic [VEC_W-1:0] j_q;
	logic [ELEM_W-1:0] e_q;
	logic [RANK_W-1:0] r_q;

	logic [7:0]        dim_eff;
	logic [ELEM_W-1:0] dim_last;
	logic [10:0]       n_eff;
	logic [VEC_W-1:0]  n_last;
	logic [CNT_W-1:0]  k_clamp, k_eff;

	logic              acc_item, q_close, issue_end, busy, res_acc;
	issue_t            tag_s0;
	score_res_t        res;
	list_ctl_t         ctl;
	score_t            head_score;
	logic [VEC_W-1:0]  head_idx;
	logic [CNT_W-1:0]  count;
	logic [ELEM_BITS-1:0] q_rd, d_rd;

	always_comb begin
		dim_eff  = (dim_q == 8'd0) ? 8'd1 : (dim_q > 8'(MAX_DIM)) ? 8'(MAX_DIM) : dim_q;
		dim_last = ELEM_W'(dim_eff - 8'd1);
		n_eff    = (ndata_q == 11'd0) ? 11'd1 :
			(ndata_q > 11'(MAX_DATA)) ? 11'(MAX_DATA) : ndata_q;
		n_last   = VEC_W'(n_eff - 11'd1);
		k_clamp  = (k_q == '0) ? CNT_W'(1) : (k_q > CNT_W'(MAX_K)) ? CNT_W'(MAX_K) : k_q;
		k_eff    = (11'(k_clamp) > n_eff) ? CNT_W'(n_eff) : k_clamp;
	end

	assign item_ch.ready = (state_q == ST_IDLE);
	assign acc_item  = item_ch.valid && item_ch.ready;
	assign q_close   = acc_item && item_ch.op && (item_ch.elem_index == dim_last);
	assign issue_end = (e_q == dim_last) && (j_q == n_last);
	assign res_acc   = result_ch.valid && result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= 1'b0;
			dim_q    <= 8'd128;
			ndata_q  <= 11'd1024;
			k_q      <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_METRIC: metric_q <= cfg_data[0];
				CFG_DIM:    dim_q    <= cfg_data[7:0];
				CFG_NDATA:  ndata_q  <= cfg_data;
				CFG_K:      k_q      <= cfg_data[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			e_q     <= '0;
			r_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_close) begin
						state_q <= ST_SCAN;
						j_q     <= '0;
						e_q     <= '0;
					end
				end
				ST_SCAN: begin
					if (e_q == dim_last) begin
						e_q <= '0;
						j_q <= j_q + 1'b1;
					end else begin
						e_q <= e_q + 1'b1;
					end
					if (issue_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last score to be ranked
					if (!busy) begin
						state_q <= ST_EMIT;
						r_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (res_acc) begin
						r_q <= r_q + 1'b1;
						if (count == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	knn_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DATA * MAX_DIM)) u_db (
		.clk   (clk),
		.we    (acc_item && !item_ch.op),
		.waddr ({item_ch.vec_index, item_ch.elem_index}),
		.wdata (item_ch.value),
		.raddr ({j_q, e_q}),
		.rdata (d_rd)
	);

	knn_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DIM)) u_query (
		.clk   (clk),
		.we    (acc_item && item_ch.op),
		.waddr (item_ch.elem_index),
		.wdata (item_ch.value),
		.raddr (e_q),
		.rdata (q_rd)
	);

	assign tag_s0.valid = (state_q == ST_SCAN);
	assign tag_s0.first = (e_q == '0);
	assign tag_s0.last  = (e_q == dim_last);
	assign tag_s0.idx   = j_q;

	knn_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.metric (metric_q),
		.tag_s0 (tag_s0),
		.q_data (q_rd),
		.d_data (d_rd),
		.res    (res),
		.busy   (busy)
	);

	assign ctl.clear  = q_close;
	assign ctl.pop    = res_acc;
	assign ctl.metric = metric_q;
	assign ctl.k      = k_eff;

	knn_topk u_topk (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.ins        (res),
		.head_score (head_score),
		.head_idx   (head_idx),
		.count      (count)
	);

	assign result_ch.valid      = (state_q == ST_EMIT);
	assign result_ch.rank       = r_q;
	assign result_ch.score      = head_score;
	assign result_ch.data_index = head_idx;
	assign result_ch.last       = (count == CNT_W'(1));

	`KNN_ASSERT_NEVER(a_no_overlap, clk, arst_n, result_ch.valid && item_ch.ready)
	`KNN_ASSERT(a_emit_nonempty, clk, arst_n, result_ch.valid |-> count != '0)
	`KNN_ASSERT(a_scan_to_drain, clk, arst_n,
		(state_q == ST_SCAN && issue_end) |=> state_q == ST_DRAIN)
endmodule

/* test/tb.sv */
// Self-checking testbench for the top-k nearest-neighbour search block.
`timescale 1ns / 1ps
module tb;
	import knn_pkg::*;

	typedef struct {
		logic [RANK_W-1:0]  rank;
		logic [SCORE_W-1:0] score;
		logic [VEC_W-1:0]   data_index;
		logic               last;
	} neighbour_t;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFGI_W-1:0] cfg_index = CFG_METRIC;
	logic [CFG_W-1:0] cfg_data = '0;

	knn_item_if item_ch();
	knn_result_if result_ch();

	brute_force_knn_topk uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_ch(item_ch),
		.result_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// shadow of the block's state
	logic signed [ELEM_BITS-1:0] db_shadow [MAX_DATA][MAX_DIM];
	bit db_written [MAX_DATA][MAX_DIM];
	logic signed [ELEM_BITS-1:0] query_shadow [MAX_DIM];
	logic metric_reg = 1'b0;
	logic [7:0] dim_reg = 8'd128;
	logic [10:0] ndata_reg = 11'd1024;
	logic [6:0] k_reg = 7'd1;

	neighbour_t expected_hits[$];
	int failures = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int ready_stall = 0;
	bit calm = 1'b0;

	initial begin
		item_ch.valid = 1'b0;
		item_ch.op = 1'b0;
		item_ch.vec_index = '0;
		item_ch.elem_index = '0;
		item_ch.value = '0;
		result_ch.ready = 1'b0;
	end

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int eff_dim();
		return clamp(dim_reg, 1, MAX_DIM);
	endfunction

	function automatic int eff_ndata();
		return clamp(ndata_reg, 1, MAX_DATA);
	endfunction

	// Score every searched vector and queue the best k in rank order.
	function automatic void rank_neighbours();
		longint best_score [MAX_K];
		int best_idx [MAX_K];
		int dim, n, k, cnt, p, i;
		longint acc, q, d;
		neighbour_t hit;
		dim = eff_dim();
		n = eff_ndata();
		k = clamp(k_reg, 1, MAX_K);
		if (k > n) k = n;
		cnt = 0;
		for (int j = 0; j < n; j++) begin
			acc = 0;
			for (int e = 0; e < dim; e++) begin
				q = query_shadow[e];
				d = db_shadow[j][e];
				if (metric_reg) acc += q * d;
				else acc += (q - d) * (q - d);
			end
			p = 0;
			while (p < cnt && !(metric_reg ? acc > best_score[p] : acc < best_score[p])) p++;
			if (p >= k) continue;
			i = (cnt < k) ? cnt : k - 1;
			while (i > p) begin
				best_score[i] = best_score[i-1];
				best_idx[i] = best_idx[i-1];
				i--;
			end
			best_score[p] = acc;
			best_idx[p] = j;
			if (cnt < k) cnt++;
		end
		for (int r = 0; r < cnt; r++) begin
			hit.rank = r[RANK_W-1:0];
			hit.score = best_score[r][SCORE_W-1:0];
			hit.data_index = best_idx[r][VEC_W-1:0];
			hit.last = (r == cnt - 1);
			expected_hits.push_back(hit);
		end
	endfunction

	function automatic logic signed [ELEM_BITS-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return ELEM_BITS'($urandom_range(0, 2) - 1);
			default: return ELEM_BITS'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		if (calm) return 0;
		case ($urandom_range(0, 19))
			0: return $urandom_range(20, 60);
			1, 2, 3, 4, 5, 6: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	// Drive one item and update the shadow state once it is accepted.
	task automatic send_item(logic op, int vec, int elem, logic signed [ELEM_BITS-1:0] val);
		repeat (pick_gap()) @(negedge clk);
		item_ch.valid = 1'b1;
		item_ch.op = op;
		item_ch.vec_index = vec[VEC_W-1:0];
		item_ch.elem_index = elem[ELEM_W-1:0];
		item_ch.value = val;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (op == 1'b0) begin
			db_shadow[vec[VEC_W-1:0]][elem[ELEM_W-1:0]] = val;
			db_written[vec[VEC_W-1:0]][elem[ELEM_W-1:0]] = 1'b1;
		end else begin
			query_shadow[elem[ELEM_W-1:0]] = val;
			if (elem == eff_dim() - 1) rank_neighbours();
		end
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_hits.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFGI_W-1:0] idx, int data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_METRIC: metric_reg = data[0];
			CFG_DIM: dim_reg = data[7:0];
			CFG_NDATA: ndata_reg = data[10:0];
			CFG_K: k_reg = data[6:0];
			default: ;
		endcase
	endtask

	task automatic configure(int metric, int dim, int ndata, int k);
		wait_idle();
		write_reg(CFG_METRIC, metric);
		write_reg(CFG_DIM, dim);
		write_reg(CFG_NDATA, ndata);
		write_reg(CFG_K, k);
	endtask

	// Write any searched element that has never been written.
	task automatic fill_database();
		for (int j = 0; j < eff_ndata(); j++)
			for (int e = 0; e < eff_dim(); e++)
				if (!db_written[j][e]) send_item(1'b0, j, e, pick_value());
	endtask

	task automatic run_query(bit stray);
		int dim;
		dim = eff_dim();
		for (int e = 0; e < dim; e++) begin
			if (stray && e == dim - 1 && dim < MAX_DIM)
				send_item(1'b1, $urandom, $urandom_range(dim, MAX_DIM - 1), pick_value());
			send_item(1'b1, $urandom, e, pick_value());
		end
	endtask

	task automatic test_l2_extremes();
		configure(0, 4, 4, 4);
		send_item(1'b0, 0, 0, -16'sd32768);
		send_item(1'b0, 0, 1, 16'sd32767);
		send_item(1'b0, 0, 2, 16'sd0);
		send_item(1'b0, 0, 3, -16'sd1);
		// equal vectors exercise the lower-index tie rule
		for (int j = 1; j < 4; j++)
			for (int e = 0; e < 4; e++) send_item(1'b0, j, e, (j == 3) ? 16'sd0 : 16'sd5);
		send_item(1'b1, 1023, 0, 16'sd32767);
		send_item(1'b1, 0, 1, -16'sd32768);
		send_item(1'b1, 0, 2, 16'sd5);
		send_item(1'b1, 0, 3, 16'sd5);
	endtask

	task automatic test_inner_product();
		configure(1, 4, 3, 8);
		run_query(1'b1);
		configure(1, 4, 4, 2);
		run_query(1'b0);
	endtask

	task automatic test_register_saturation();
		configure(0, 0, 0, 0);
		run_query(1'b0);
		configure(1, 255, 1, 127);
		fill_database();
		run_query(1'b0);
		configure(0, 1, 40, 127);
		fill_database();
		run_query(1'b0);
		configure(1, 1, 40, 64);
		run_query(1'b0);
	endtask

	task automatic test_random_traffic();
		while (items_sent < 430) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) == 0)
				configure($urandom_range(0, 1), $urandom_range(1, 3),
					$urandom_range(60, 80), 64);
			else
				configure($urandom_range(0, 1), $urandom_range(1, 8),
					$urandom_range(1, 12), $urandom_range(1, 16));
			fill_database();
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 4))
					send_item(1'b0, $urandom, $urandom, pick_value());
				run_query($urandom_range(0, 1));
			end
		end
		calm = 1'b0;
	endtask

	always @(negedge clk) begin
		if (ready_stall > 0) begin
			result_ch.ready = 1'b0;
			ready_stall--;
		end else begin
			result_ch.ready = 1'b1;
			if (!calm && $urandom_range(0, 5) == 0)
				ready_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		neighbour_t want;
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_hits.size() == 0) begin
					$error("unexpected result, rank %0d", result_ch.rank);
					failures++;
				end else begin
					want = expected_hits.pop_front();
					if (result_ch.rank !== want.rank) begin
						$error("rank: expected %0d, got %0d", want.rank, result_ch.rank);
						failures++;
					end
					if (result_ch.score !== want.score) begin
						$error("score: expected %0h, got %0h", want.score, result_ch.score);
						failures++;
					end
					if (result_ch.data_index !== want.data_index) begin
						$error("data_index: expected %0d, got %0d", want.data_index,
							result_ch.data_index);
						failures++;
					end
					if (result_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result_ch.last);
						failures++;
					end
				end
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_l2_extremes();
		test_inner_product();
		test_register_saturation();
		test_random_traffic();
		wait_idle();
		if (expected_hits.size() != 0) failures++;
		if (failures == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+sv
sv/knn_pkg.sv
sv/knn_if.sv
sv/knn_ram.sv
sv/knn_score.sv
sv/knn_topk.sv
sv/brute_force_knn_topk.sv
test/tb.sv
